FILE: rtl/psat_pkg.sv
// ----------------------------------------------------------------------------
// psat_pkg
// Shared types, widths and helpers for the per-source attempt throttle.
// ----------------------------------------------------------------------------
package psat_pkg;

  // defaults for the table geometry
  localparam int unsigned BUCKET_BITS_DEF = 6;
  localparam int unsigned WAYS_DEF        = 4;

  // field widths
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned WIN_W      = 31;
  localparam int unsigned HASH_W     = 16;
  localparam int unsigned V4_W       = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned VERD_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  // leading word of the 6to4 prefix used for IPv4 sources
  localparam logic [HASH_W-1:0] SIXTOFOUR_WORD = 16'h2002;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK  = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_LIMIT = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_GLB_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [VERD_W-1:0] {
    VERD_OK  = 2'd0,
    VERD_SRC = 2'd1,
    VERD_GLB = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_COMMIT,
    ST_EXP_RD,
    ST_EXP_WR,
    ST_RESP
  } state_e;

  // canonical 64-bit source key
  function automatic logic [KEY_W-1:0] make_key(input logic            is_v4,
                                                input logic [KEY_W-1:0] prefix,
                                                input logic [V4_W-1:0]  v4);
    logic [KEY_W-1:0] k;
    if (is_v4) begin
      k = {SIXTOFOUR_WORD, v4, {HASH_W{1'b0}}};
    end else begin
      k = prefix;
    end
    return k;
  endfunction

  // XOR of the four big-endian 16-bit words
  function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_W-1:0] key);
    return key[63:48] ^ key[47:32] ^ key[31:16] ^ key[15:0];
  endfunction

endpackage

FILE: rtl/psat_scan.sv
// ----------------------------------------------------------------------------
// psat_scan
// Compares the ways of one bucket row against a key: finds the live hit,
// the first dead way and the oldest live way, and registers the outcome.
// ----------------------------------------------------------------------------
module psat_scan #(
  parameter int unsigned WAYS  = psat_pkg::WAYS_DEF,
  parameter int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [psat_pkg::TIME_W-1:0]            now_i,
  input  logic [psat_pkg::WIN_W-1:0]             window_i,
  input  logic [psat_pkg::KEY_W-1:0]             key_i,
  input  logic [WAYS-1:0]                        valid_i,
  input  logic [WAYS-1:0][psat_pkg::KEY_W-1:0]   key_row_i,
  input  logic [WAYS-1:0][psat_pkg::TIME_W-1:0]  stamp_i,
  input  logic [WAYS-1:0][psat_pkg::CNT_W-1:0]   count_i,
  output logic                                   hit_o,
  output logic [WAY_W-1:0]                       hit_way_o,
  output logic [WAY_W-1:0]                       victim_way_o,
  output logic [psat_pkg::CNT_W-1:0]             hit_count_o
);
  import psat_pkg::*;

  logic [WAYS-1:0][TIME_W-1:0] age;
  logic [WAYS-1:0]             live;
  logic                        hit, have_free, have_old;
  logic [WAY_W-1:0]            hit_way, free_way, old_way;
  logic [TIME_W-1:0]           old_age;

  logic                        hit_q;
  logic [WAY_W-1:0]            hit_way_q, victim_way_q;
  logic [CNT_W-1:0]            hit_count_q;

  // per-way age and liveness
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      age[w]  = now_i - stamp_i[w];
      live[w] = valid_i[w] && (age[w] < {1'b0, window_i});
    end
  end

  // first live match, first dead way, oldest live way (first of equals)
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    have_free = 1'b0;
    free_way  = '0;
    have_old  = 1'b0;
    old_way   = '0;
    old_age   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && live[w] && (key_row_i[w] == key_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!have_free && !live[w]) begin
        have_free = 1'b1;
        free_way  = WAY_W'(w);
      end
      if (live[w] && (!have_old || (age[w] > old_age))) begin
        have_old = 1'b1;
        old_way  = WAY_W'(w);
        old_age  = age[w];
      end
    end
  end

  // outcome register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q        <= hit;
      hit_way_q    <= hit_way;
      victim_way_q <= have_free ? free_way : old_way;
      hit_count_q  <= count_i[hit_way];
    end
  end

  assign hit_o        = hit_q;
  assign hit_way_o    = hit_way_q;
  assign victim_way_o = victim_way_q;
  assign hit_count_o  = hit_count_q;

endmodule

FILE: rtl/per_source_attempt_throttle.sv
// ----------------------------------------------------------------------------
// per_source_attempt_throttle
// Admits or refuses attempts per source key against a bucketed way table
// held in one synchronous memory, plus a global fixed-window counter.
// ----------------------------------------------------------------------------
// Check with a source: memory read, way scan, commit and write-back of one bucket
//   row; the input stays stalled until the verdict is out, so checks do not overlap.
// Check without source, zero window or unused op: the bucket memory is not used.
// Expire: a read and a write per bucket row, over every row.
// Clear: writes every bucket row to zero. After reset a clearing pass
//   runs with the input stalled; config writes are taken.
module per_source_attempt_throttle #(
  parameter int unsigned BUCKET_BITS = psat_pkg::BUCKET_BITS_DEF,
  parameter int unsigned WAYS        = psat_pkg::WAYS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [psat_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psat_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [psat_pkg::OP_W-1:0]         op_i,
  input  logic [psat_pkg::TIME_W-1:0]       now_i,
  input  logic                              has_source_i,
  input  logic                              source_is_ipv4_i,
  input  logic [psat_pkg::KEY_W-1:0]        ipv6_prefix_i,
  input  logic [psat_pkg::V4_W-1:0]         ipv4_address_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [psat_pkg::VERD_W-1:0]       verdict_o
);
  import psat_pkg::*;

  localparam int unsigned Buckets = 1 << BUCKET_BITS;
  localparam int unsigned WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][KEY_W-1:0]  key;
    logic [WAYS-1:0][TIME_W-1:0] stamp;
    logic [WAYS-1:0][CNT_W-1:0]  count;
  } row_t;

  // control state
  state_e                 state_q, state_d;
  logic [BUCKET_BITS-1:0] ptr_q, ptr_d;
  logic                   clr_resp_q, clr_resp_d;
  logic                   out_valid_q, out_valid_d;
  logic [TIME_W-1:0]      gws_q, gws_d;
  logic [CNT_W-1:0]       gcnt_q, gcnt_d;
  logic [CNT_W-1:0]       src_limit_q;
  logic [WIN_W-1:0]       window_q;
  logic [CNT_W-1:0]       glb_limit_q;

  // payload registers
  verdict_e               verdict_q, verdict_d;
  verdict_e               pend_q, pend_d;
  logic [TIME_W-1:0]      now_q, now_d;
  logic                   use_src_q, use_src_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [BUCKET_BITS-1:0] bucket_q, bucket_d;

  // memory
  row_t                   mem [Buckets];
  row_t                   rdata_q;
  logic                   mem_re, mem_we;
  logic [BUCKET_BITS-1:0] mem_raddr, mem_waddr;
  row_t                   mem_wdata;

  // scan outcome
  logic                   hit;
  logic [WayW-1:0]        hit_way, victim_way;
  logic [CNT_W-1:0]       hit_count;

  // decision
  logic                   out_free, ptr_last, fin;
  verdict_e               fin_verdict, commit_verdict;
  logic                   glb_on, g_restart, src_refuse, glb_refuse;
  logic [TIME_W-1:0]      g_age;
  logic [CNT_W-1:0]       g_cnt_eff;
  logic [KEY_W-1:0]       in_key;
  logic [HASH_W-1:0]      in_hash;
  row_t                   row_upd, row_exp;

  // incoming key and bucket
  assign in_key  = make_key(source_is_ipv4_i, ipv6_prefix_i, ipv4_address_i);
  assign in_hash = fold_hash(in_key);

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_limit_q <= '0;
      window_q    <= '0;
      glb_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SRC_LIMIT: src_limit_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_WINDOW:    window_q    <= cfg_wdata_i[WIN_W-1:0];
        CFG_GLB_LIMIT: glb_limit_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- bucket memory, one row of all ways per bucket ----
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // ---- way scan ----
  psat_scan #(
    .WAYS  (WAYS),
    .WAY_W (WayW)
  ) u_scan (
    .clk_i        (clk_i),
    .en_i         (state_q == ST_SCAN),
    .now_i        (now_q),
    .window_i     (window_q),
    .key_i        (key_q),
    .valid_i      (rdata_q.valid),
    .key_row_i    (rdata_q.key),
    .stamp_i      (rdata_q.stamp),
    .count_i      (rdata_q.count),
    .hit_o        (hit),
    .hit_way_o    (hit_way),
    .victim_way_o (victim_way),
    .hit_count_o  (hit_count)
  );

  // ---- verdict of a check and global window ----
  always_comb begin
    glb_on     = (glb_limit_q != '0);
    g_age      = now_q - gws_q;
    g_restart  = (g_age >= {1'b0, window_q});
    g_cnt_eff  = g_restart ? '0 : gcnt_q;
    src_refuse = use_src_q && hit && (hit_count >= src_limit_q);
    glb_refuse = glb_on && (g_cnt_eff >= glb_limit_q);
    if (src_refuse) begin
      commit_verdict = VERD_SRC;
    end else if (glb_refuse) begin
      commit_verdict = VERD_GLB;
    end else begin
      commit_verdict = VERD_OK;
    end
  end

  // row after a counted attempt
  always_comb begin
    row_upd = rdata_q;
    if (hit) begin
      row_upd.count[hit_way] = hit_count + 1'b1;
      row_upd.stamp[hit_way] = now_q;
    end else begin
      row_upd.valid[victim_way] = 1'b1;
      row_upd.key[victim_way]   = key_q;
      row_upd.stamp[victim_way] = now_q;
      row_upd.count[victim_way] = CNT_W'(1);
    end
  end

  // row after ageing out; a zero window drops every entry
  always_comb begin
    row_exp = rdata_q;
    for (int w = 0; w < WAYS; w++) begin
      if ((now_q - rdata_q.stamp[w]) >= {1'b0, window_q}) begin
        row_exp.valid[w] = 1'b0;
      end
    end
  end

  // ---- operation completion ----
  assign out_free = !out_valid_q || !out_stall_i;
  assign ptr_last = &ptr_q;

  always_comb begin
    fin         = 1'b0;
    fin_verdict = VERD_OK;
    case (state_q)
      ST_COMMIT: begin
        fin         = 1'b1;
        fin_verdict = commit_verdict;
      end
      ST_EXP_WR: fin = ptr_last;
      ST_INIT:   fin = ptr_last && clr_resp_q;
      ST_RESP: begin
        fin         = 1'b1;
        fin_verdict = pend_q;
      end
      default: ;
    endcase
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (ptr_last) begin
          state_d = (clr_resp_q && !out_free) ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_CHECK: begin
              if (window_q == '0) begin
                state_d = ST_RESP;
              end else if (has_source_i && (src_limit_q != '0)) begin
                state_d = ST_RD;
              end else begin
                state_d = ST_COMMIT;
              end
            end
            OP_EXPIRE: state_d = ST_EXP_RD;
            OP_CLEAR:  state_d = ST_INIT;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_RD:     state_d = ST_SCAN;
      ST_SCAN:   state_d = ST_COMMIT;
      ST_COMMIT: state_d = out_free ? ST_IDLE : ST_RESP;
      ST_EXP_RD: state_d = ST_EXP_WR;
      ST_EXP_WR: begin
        if (ptr_last) begin
          state_d = out_free ? ST_IDLE : ST_RESP;
        end else begin
          state_d = ST_EXP_RD;
        end
      end
      ST_RESP:   state_d = out_free ? ST_IDLE : ST_RESP;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---- datapath and memory control ----
  always_comb begin
    ptr_d       = ptr_q;
    clr_resp_d  = clr_resp_q;
    gws_d       = gws_q;
    gcnt_d      = gcnt_q;
    pend_d      = pend_q;
    now_d       = now_q;
    use_src_d   = use_src_q;
    key_d       = key_q;
    bucket_d    = bucket_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_re      = 1'b0;
    mem_raddr   = bucket_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = row_upd;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_last) begin
          clr_resp_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          now_d     = now_i;
          use_src_d = has_source_i && (src_limit_q != '0);
          key_d     = in_key;
          bucket_d  = in_hash[BUCKET_BITS-1:0];
          ptr_d     = '0;
          pend_d    = VERD_OK;
          if (op_e'(op_i) == OP_CLEAR) begin
            gws_d      = '0;
            gcnt_d     = '0;
            clr_resp_d = 1'b1;
          end
        end
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_COMMIT: begin
        if (!src_refuse && glb_on && g_restart) begin
          gws_d  = now_q;
          gcnt_d = '0;
        end
        if (commit_verdict == VERD_OK) begin
          if (glb_on) begin
            gcnt_d = g_cnt_eff + 1'b1;
          end
          if (use_src_q) begin
            mem_we    = 1'b1;
            mem_waddr = bucket_q;
          end
        end
      end
      ST_EXP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q;
      end
      ST_EXP_WR: begin
        mem_we    = 1'b1;
        mem_wdata = row_exp;
        ptr_d     = ptr_q + 1'b1;
      end
      default: ;
    endcase

    // hand the verdict to the output register, or hold it back
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        verdict_d   = fin_verdict;
      end else begin
        pend_d = fin_verdict;
      end
    end
  end

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
      gws_q       <= '0;
      gcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
      gws_q       <= gws_d;
      gcnt_q      <= gcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    pend_q    <= pend_d;
    now_q     <= now_d;
    use_src_q <= use_src_d;
    key_q     <= key_d;
    bucket_q  <= bucket_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule
